// File: design/fndr_pkg.sv
// Shared types and constants for the face normal / diffuse / reflection block.
// No dependencies.
package fndr_pkg;

   localparam int UNIT_Q14  = 16384;
   localparam int ROUND_Q14 = 8192;
   localparam int CROSS_TOP = 29;
   localparam int ROOT_W    = 31;
   localparam int SQ_W      = 62;
   localparam int QUO_W     = 15;
   localparam int NUM_W     = 45;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LIGHT_X = 3'd0,
      CSR_LIGHT_Y = 3'd1,
      CSR_LIGHT_Z = 3'd2,
      CSR_DIFFUSE = 3'd3,
      CSR_AMBIENT = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic signed [31:0] p2_z;
      logic signed [31:0] p2_y;
      logic signed [31:0] p2_x;
      logic signed [31:0] p1_z;
      logic signed [31:0] p1_y;
      logic signed [31:0] p1_x;
      logic signed [31:0] p0_z;
      logic signed [31:0] p0_y;
      logic signed [31:0] p0_x;
   } face_type;

   typedef struct packed {
      logic signed [15:0] n_z;
      logic signed [15:0] n_y;
      logic signed [15:0] n_x;
   } nrm_type;

   typedef struct packed {
      logic signed [15:0] reflect_z;
      logic signed [15:0] reflect_y;
      logic signed [15:0] reflect_x;
      logic [47:0]        lit_combined_rgb;
      logic [47:0]        lit_diffuse_rgb;
      logic               in_shadow;
      nrm_type            normal;
   } shade_type;

endpackage

// File: design/face_normal_diffuse_reflect.sv
// Per-face unit normal, Lambert diffuse shading and light reflection vector.
// Depends on fndr_pkg, fndr_front, fndr_queue, fndr_back.
//
// Usage:
//   req_*  : one face per transfer, three Q16.16 corner points.
//   rsp_*  : one shading result per face, in input order.
//   csr_*  : light direction and material colours; write only while idle.
// Throughput: one face per cycle while no stage is held by a full queue or a
//   low rsp_tready.  The front pipeline holds a 32-stage square-root pipeline
//   and a 16-stage normalizing divider.
// A four-entry queue splits the front (geometry) from the back (shading);
// each side holds on its own when the next one is full.  The rsp register
// holds a result while rsp_tready is low, and req_tready stays high as long
// as the front pipeline can still move.
// Reset clears all pipeline valid bits and the queue, and loads the
// registers with light (0, 1, 0) and black diffuse and ambient colours.
module face_normal_diffuse_reflect import fndr_pkg::*; #(
   parameter int COLOR_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z (32 bits each)
   input  logic [287:0]         req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // normal_x, normal_y, normal_z, lit_diffuse_rgb, lit_combined_rgb,
   // reflect_x, reflect_y, reflect_z
   output logic [191:0]         rsp_tdata,
   // in_shadow
   output logic                 rsp_tuser,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [47:0]          csr_wdata
);

   // configuration registers
   logic signed [15:0] light_ff [3];
   logic [47:0]        diffuse_ff, ambient_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         light_ff[0] <= '0;
         light_ff[1] <= 16'(UNIT_Q14);
         light_ff[2] <= '0;
         diffuse_ff  <= '0;
         ambient_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LIGHT_X: light_ff[0] <= csr_wdata[15:0];
            CSR_LIGHT_Y: light_ff[1] <= csr_wdata[15:0];
            CSR_LIGHT_Z: light_ff[2] <= csr_wdata[15:0];
            CSR_DIFFUSE: diffuse_ff  <= csr_wdata;
            CSR_AMBIENT: ambient_ff  <= csr_wdata;
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   face_type face;
   assign face = face_type'(req_tdata);

   logic    f_valid, q_full, q_ne, b_ready;
   nrm_type f_item, q_item;

   fndr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_face   (face),
      .out_valid (f_valid),
      .out_item  (f_item),
      .out_ready (!q_full)
   );

   fndr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid && !q_full),
      .push_item (f_item),
      .full      (q_full),
      .pop       (q_ne && b_ready),
      .not_empty (q_ne),
      .pop_item  (q_item)
   );

   shade_type res;

   fndr_back #(.COLOR_BITS(COLOR_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (q_ne),
      .in_ready    (b_ready),
      .in_item     (q_item),
      .light       (light_ff),
      .diffuse_rgb (diffuse_ff),
      .ambient_rgb (ambient_ff),
      .out_valid   (rsp_tvalid),
      .out_item    (res),
      .out_ready   (rsp_tready)
   );

   assign rsp_tdata = {res.reflect_z, res.reflect_y, res.reflect_x,
                       res.lit_combined_rgb, res.lit_diffuse_rgb,
                       res.normal.n_z, res.normal.n_y, res.normal.n_x};
   assign rsp_tuser = res.in_shadow;

endmodule

// File: design/fndr_isqrt.sv
// Pipelined integer square root, one root bit per stage, with a sideband.
// Depends on fndr_pkg.
module fndr_isqrt import fndr_pkg::*; #(
   parameter int SIDE_W = 94
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [SQ_W-1:0]     in_x,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic [ROOT_W-1:0]   out_root,
   output logic [SIDE_W-1:0]   out_side
);

   logic [63:0]       rem_ff  [ROOT_W+1];
   logic [63:0]       rem_in  [ROOT_W+1];
   logic [ROOT_W-1:0] root_ff [ROOT_W+1];
   logic [ROOT_W-1:0] root_in [ROOT_W+1];
   logic [SIDE_W-1:0] side_ff [ROOT_W+1];
   logic              vld_ff  [ROOT_W+1];

   always_comb begin
      rem_in[0]  = 64'(in_x);
      root_in[0] = '0;
      for (int k = 1; k <= ROOT_W; k++) begin
         logic [63:0] term;
         int          b;
         b = ROOT_W - k;
         term = (64'(root_ff[k-1]) << (b + 1)) + (64'd1 << (2 * b));
         if (rem_ff[k-1] >= term) begin
            rem_in[k]  = rem_ff[k-1] - term;
            root_in[k] = root_ff[k-1] | (ROOT_W'(1) << b);
         end else begin
            rem_in[k]  = rem_ff[k-1];
            root_in[k] = root_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= ROOT_W; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k <= ROOT_W; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int k = 0; k <= ROOT_W; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
         end
         for (int k = 1; k <= ROOT_W; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   assign out_valid = vld_ff[ROOT_W];
   assign out_root  = root_ff[ROOT_W];
   assign out_side  = side_ff[ROOT_W];

endmodule

// File: design/fndr_front.sv
// Front pipeline: edges, cross product, scaling, length and unit normal.
// Depends on fndr_pkg and fndr_isqrt.
module fndr_front import fndr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  face_type in_face,
   output logic     out_valid,
   output nrm_type  out_item,
   input  logic     out_ready
);

   localparam int SIDE_W = 3 * 30 + 3 + 1;

   logic adv;
   assign adv      = out_ready || !out_valid;
   assign in_ready = adv;

   // stage 1: capture
   face_type face_ff;
   logic     v1_ff;
   logic signed [31:0] pt [9];
   always_comb begin
      pt[0] = face_ff.p0_x; pt[1] = face_ff.p0_y; pt[2] = face_ff.p0_z;
      pt[3] = face_ff.p1_x; pt[4] = face_ff.p1_y; pt[5] = face_ff.p1_z;
      pt[6] = face_ff.p2_x; pt[7] = face_ff.p2_y; pt[8] = face_ff.p2_z;
   end

   // stage 2: edges and common pre-shift
   logic signed [32:0] ue_in [3], ve_in [3], ue_ff [3], ve_ff [3];
   logic [1:0]         esh_in, esh_ff;
   logic               v2_ff;
   always_comb begin
      logic [32:0] orv;
      orv = '0;
      for (int i = 0; i < 3; i++) begin
         ue_in[i] = 33'(pt[i])     - 33'(pt[3+i]);
         ve_in[i] = 33'(pt[6+i])   - 33'(pt[3+i]);
         orv = orv | (ue_in[i][32] ? 33'(-ue_in[i]) : 33'(ue_in[i]));
         orv = orv | (ve_in[i][32] ? 33'(-ve_in[i]) : 33'(ve_in[i]));
      end
      if (orv[32])      esh_in = 2'd3;
      else if (orv[31]) esh_in = 2'd2;
      else if (orv[30]) esh_in = 2'd1;
      else              esh_in = 2'd0;
   end

   // stage 3: shifted edges, truncating toward zero
   logic signed [30:0] us_in [3], vs_in [3], us_ff [3], vs_ff [3];
   logic               v3_ff;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [32:0] mu, mv;
         mu = ue_ff[i][32] ? 33'(-ue_ff[i]) : 33'(ue_ff[i]);
         mv = ve_ff[i][32] ? 33'(-ve_ff[i]) : 33'(ve_ff[i]);
         mu = mu >> esh_ff;
         mv = mv >> esh_ff;
         us_in[i] = ue_ff[i][32] ? 31'(-mu) : 31'(mu);
         vs_in[i] = ve_ff[i][32] ? 31'(-mv) : 31'(mv);
      end
   end

   // stage 4: partial products
   logic signed [61:0] pr_in [6], pr_ff [6];
   logic               v4_ff;
   always_comb begin
      pr_in[0] = us_ff[1] * vs_ff[2];
      pr_in[1] = us_ff[2] * vs_ff[1];
      pr_in[2] = us_ff[2] * vs_ff[0];
      pr_in[3] = us_ff[0] * vs_ff[2];
      pr_in[4] = us_ff[0] * vs_ff[1];
      pr_in[5] = us_ff[1] * vs_ff[0];
   end

   // stage 5: cross product as sign and magnitude
   logic [60:0] cm_in [3], cm_ff [3], cm6_ff [3];
   logic [2:0]  cs_in, cs_ff, cs6_ff, cs7_ff, cs8_ff, cs9_ff;
   logic        v5_ff;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic signed [61:0] c;
         c = pr_ff[2*i] - pr_ff[2*i+1];
         cs_in[i] = c[61];
         cm_in[i] = c[61] ? 61'(-c) : 61'(c);
      end
   end

   // stage 6: leading one of the largest magnitude
   logic [5:0] top_in, top_ff;
   logic       nz_in, nz6_ff, nz7_ff, nz8_ff, nz9_ff;
   logic       v6_ff;
   always_comb begin
      logic [60:0] orv;
      orv    = cm_ff[0] | cm_ff[1] | cm_ff[2];
      nz_in  = |orv;
      top_in = '0;
      for (int b = 0; b < 61; b++) begin
         if (orv[b]) top_in = 6'(b);
      end
   end

   // stage 7: scale so the top bit lands on bit CROSS_TOP
   logic [29:0] sm_in [3], sm_ff [3], sm8_ff [3], sm9_ff [3];
   logic        v7_ff;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [60:0] t;
         if (top_ff > 6'(CROSS_TOP)) t = cm6_ff[i] >> (top_ff - 6'(CROSS_TOP));
         else                        t = cm6_ff[i] << (6'(CROSS_TOP) - top_ff);
         sm_in[i] = t[29:0];
      end
   end

   // stage 8: squares, stage 9: sum of squares
   logic [59:0]     sq_ff [3];
   logic [SQ_W-1:0] ssum_ff;
   logic            v8_ff, v9_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0; v5_ff <= 1'b0;
         v6_ff <= 1'b0; v7_ff <= 1'b0; v8_ff <= 1'b0; v9_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid; v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
         v5_ff <= v4_ff; v6_ff <= v5_ff; v7_ff <= v6_ff; v8_ff <= v7_ff;
         v9_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         face_ff <= in_face;
         esh_ff  <= esh_in;
         top_ff  <= top_in;
         cs_ff   <= cs_in;  cs6_ff <= cs_ff; cs7_ff <= cs6_ff;
         cs8_ff  <= cs7_ff; cs9_ff <= cs8_ff;
         nz6_ff  <= nz_in;  nz7_ff <= nz6_ff; nz8_ff <= nz7_ff; nz9_ff <= nz8_ff;
         ssum_ff <= 62'(sq_ff[0]) + 62'(sq_ff[1]) + 62'(sq_ff[2]);
         for (int i = 0; i < 3; i++) begin
            ue_ff[i]  <= ue_in[i];
            ve_ff[i]  <= ve_in[i];
            us_ff[i]  <= us_in[i];
            vs_ff[i]  <= vs_in[i];
            cm_ff[i]  <= cm_in[i];
            cm6_ff[i] <= cm_ff[i];
            sm_ff[i]  <= sm_in[i];
            sm8_ff[i] <= sm_ff[i];
            sm9_ff[i] <= sm8_ff[i];
            sq_ff[i]  <= sm_ff[i] * sm_ff[i];
         end
         for (int i = 0; i < 6; i++) pr_ff[i] <= pr_in[i];
      end
   end

   // length
   logic              sq_valid;
   logic [ROOT_W-1:0] len;
   logic [SIDE_W-1:0] side_out;

   fndr_isqrt #(.SIDE_W(SIDE_W)) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v9_ff),
      .in_x      (ssum_ff),
      .in_side   ({sm9_ff[2], sm9_ff[1], sm9_ff[0], cs9_ff, nz9_ff}),
      .out_valid (sq_valid),
      .out_root  (len),
      .out_side  (side_out)
   );

   // restoring divide: q = (m * 2^14 + len/2) / len, one quotient bit a stage
   logic [NUM_W-1:0]  drem_ff [3][QUO_W+1];
   logic [NUM_W-1:0]  drem_in [3][QUO_W+1];
   logic [QUO_W-1:0]  dq_ff   [3][QUO_W+1];
   logic [QUO_W-1:0]  dq_in   [3][QUO_W+1];
   logic [ROOT_W-1:0] dlen_ff [QUO_W+1];
   logic [2:0]        dcs_ff  [QUO_W+1];
   logic              dnz_ff  [QUO_W+1];
   logic              dv_ff   [QUO_W+1];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         drem_in[i][0] = (NUM_W'(side_out[4+30*i +: 30]) << 14) + NUM_W'(len >> 1);
         dq_in[i][0]   = '0;
         for (int k = 1; k <= QUO_W; k++) begin
            logic [NUM_W-1:0] dsub;
            dsub = NUM_W'(dlen_ff[k-1]) << (QUO_W - k);
            if (drem_ff[i][k-1] >= dsub) begin
               drem_in[i][k] = drem_ff[i][k-1] - dsub;
               dq_in[i][k]   = dq_ff[i][k-1] | (QUO_W'(1) << (QUO_W - k));
            end else begin
               drem_in[i][k] = drem_ff[i][k-1];
               dq_in[i][k]   = dq_ff[i][k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QUO_W; k++) dv_ff[k] <= 1'b0;
      end else if (adv) begin
         dv_ff[0] <= sq_valid;
         for (int k = 1; k <= QUO_W; k++) dv_ff[k] <= dv_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dlen_ff[0] <= len;
         dcs_ff[0]  <= side_out[3:1];
         dnz_ff[0]  <= side_out[0];
         for (int k = 1; k <= QUO_W; k++) begin
            dlen_ff[k] <= dlen_ff[k-1];
            dcs_ff[k]  <= dcs_ff[k-1];
            dnz_ff[k]  <= dnz_ff[k-1];
         end
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k <= QUO_W; k++) begin
               drem_ff[i][k] <= drem_in[i][k];
               dq_ff[i][k]   <= dq_in[i][k];
            end
         end
      end
   end

   logic signed [15:0] nv [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (!dnz_ff[QUO_W])        nv[i] = '0;
         else if (dcs_ff[QUO_W][i]) nv[i] = -16'(dq_ff[i][QUO_W]);
         else                       nv[i] = 16'(dq_ff[i][QUO_W]);
      end
   end

   assign out_valid      = dv_ff[QUO_W];
   assign out_item.n_x   = nv[0];
   assign out_item.n_y   = nv[1];
   assign out_item.n_z   = nv[2];

endmodule

// File: design/fndr_queue.sv
// Four-entry queue of unit normals between front and back pipelines.
// Depends on fndr_pkg.
module fndr_queue import fndr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  nrm_type push_item,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output nrm_type pop_item
);

   localparam int DEPTH = 4;

   nrm_type    mem_ff [DEPTH];
   logic [1:0] wptr_ff, rptr_ff;
   logic [2:0] cnt_ff;

   assign full      = (cnt_ff == 3'(DEPTH));
   assign not_empty = (cnt_ff != 3'd0);
   assign pop_item  = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (push) wptr_ff <= wptr_ff + 2'd1;
         if (pop)  rptr_ff <= rptr_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(push) - 3'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= push_item;
   end

endmodule

// File: design/fndr_back.sv
// Back pipeline: light factor, shadow test, diffuse, combined and reflection.
// Depends on fndr_pkg.
module fndr_back import fndr_pkg::*; #(
   parameter int COLOR_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  nrm_type            in_item,
   input  logic signed [15:0] light [3],
   input  logic [47:0]        diffuse_rgb,
   input  logic [47:0]        ambient_rgb,
   output logic               out_valid,
   output shade_type          out_item,
   input  logic               out_ready
);

   localparam int DP_W = COLOR_BITS + 15;
   localparam logic [COLOR_BITS-1:0] CMAX = '1;

   logic adv;
   assign adv      = out_ready || !out_valid;
   assign in_ready = adv;

   logic signed [15:0] n_in [3];
   assign n_in[0] = in_item.n_x;
   assign n_in[1] = in_item.n_y;
   assign n_in[2] = in_item.n_z;

   // stage 1: N.L partial products
   nrm_type            n1_ff, n2_ff, n3_ff;
   logic signed [31:0] pl_ff [3];
   logic               v1_ff, v2_ff, v3_ff, vo_ff;

   // stage 2: nl28, shadow, rounded and clamped nl
   logic [14:0] nl_in, nl_ff;
   logic        sh_in, sh2_ff, sh3_ff;
   always_comb begin
      logic signed [33:0] nl28;
      logic [33:0]        r;
      nl28  = 34'(pl_ff[0]) + 34'(pl_ff[1]) + 34'(pl_ff[2]);
      sh_in = nl28[33];
      r     = 34'(nl28) + 34'(ROUND_Q14);
      if (r[33:14] > 20'(UNIT_Q14)) nl_in = 15'(UNIT_Q14);
      else                          nl_in = r[28:14];
   end

   // stage 3: colour and reflection products
   logic [DP_W-1:0]    dp_ff [3];
   logic signed [31:0] rp_ff [3];
   logic signed [15:0] n2v [3];
   assign n2v[0] = n2_ff.n_x;
   assign n2v[1] = n2_ff.n_y;
   assign n2v[2] = n2_ff.n_z;

   logic [COLOR_BITS-1:0] dch [3];
   always_comb begin
      logic [63:0] dext;
      for (int i = 0; i < 3; i++) begin
         dext   = 64'(diffuse_rgb) >> (i * COLOR_BITS);
         dch[i] = dext[COLOR_BITS-1:0];
      end
   end

   // stage 4: round, saturate, clamp into the output register
   shade_type res_in, res_ff;
   always_comb begin
      logic [63:0] dacc, cacc, ash;
      logic [COLOR_BITS-1:0] ld;
      logic [COLOR_BITS:0]   sum;
      logic [DP_W:0]         dr;
      logic signed [31:0]    prod;
      logic [31:0]           pm;
      logic [17:0]           t;
      logic signed [19:0]    r;
      logic signed [15:0]    rc [3];
      dacc = '0;
      cacc = '0;
      for (int i = 0; i < 3; i++) begin
         ash  = 64'(ambient_rgb) >> (i * COLOR_BITS);
         dr   = (DP_W+1)'(dp_ff[i]) + (DP_W+1)'(ROUND_Q14);
         ld   = dr[COLOR_BITS+13:14];
         sum  = (COLOR_BITS+1)'(ash[COLOR_BITS-1:0]) + (COLOR_BITS+1)'(ld);
         if (sum[COLOR_BITS]) sum = {1'b0, CMAX};
         dacc = dacc | (64'(ld) << (i * COLOR_BITS));
         cacc = cacc | (64'(sum[COLOR_BITS-1:0]) << (i * COLOR_BITS));
         prod = rp_ff[i] <<< 1;
         pm   = prod[31] ? 32'(-prod) : 32'(prod);
         t    = 18'((pm + 32'(ROUND_Q14)) >> 14);
         r    = (prod[31] ? -20'(t) : 20'(t)) - 20'(light[i]);
         if (r > 20'sd16384)       rc[i] = 16'(UNIT_Q14);
         else if (r < -20'sd16384) rc[i] = -16'(UNIT_Q14);
         else                      rc[i] = r[15:0];
      end
      res_in.normal    = n3_ff;
      res_in.in_shadow = sh3_ff;
      if (sh3_ff) begin
         res_in.lit_diffuse_rgb  = '0;
         res_in.lit_combined_rgb = '0;
         res_in.reflect_x        = '0;
         res_in.reflect_y        = '0;
         res_in.reflect_z        = '0;
      end else begin
         res_in.lit_diffuse_rgb  = dacc[47:0];
         res_in.lit_combined_rgb = cacc[47:0];
         res_in.reflect_x        = rc[0];
         res_in.reflect_y        = rc[1];
         res_in.reflect_z        = rc[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; vo_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid; v2_ff <= v1_ff; v3_ff <= v2_ff; vo_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n1_ff  <= in_item;
         n2_ff  <= n1_ff;
         n3_ff  <= n2_ff;
         nl_ff  <= nl_in;
         sh2_ff <= sh_in;
         sh3_ff <= sh2_ff;
         res_ff <= res_in;
         for (int i = 0; i < 3; i++) begin
            pl_ff[i] <= n_in[i] * light[i];
            dp_ff[i] <= DP_W'(dch[i]) * DP_W'(nl_ff);
            rp_ff[i] <= $signed({1'b0, nl_ff}) * n2v[i];
         end
      end
   end

   assign out_valid = vo_ff;
   assign out_item  = res_ff;

endmodule
